FILE: hw/rtl/tcf_pkg.sv
// Shared types, constants and tables of the tilt complementary filter.
package tcf_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int ITER_W = $clog2(CORDIC_ITERATIONS + 1);

    localparam logic signed [28:0] HALF_PI_Q24 = 29'sd26353589;
    localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
    localparam logic [9:0] MS_PER_S = 10'd1000;
    // divide by 1000 in 16-bit digits: reciprocal ceil(2^36 / 1000)
    localparam int DIV_STEPS = 6;
    localparam int DIV_SHIFT = 36;
    localparam logic [26:0] DIV_RECIP = 27'd68719477;

    typedef enum logic [1:0] {
        CFG_GYRO_RANGE   = 2'd0,
        CFG_GYRO_BIAS    = 2'd1,
        CFG_BLEND_WEIGHT = 2'd2,
        CFG_GAP_LIMIT    = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_DIV,
        ST_BL1,
        ST_BL2,
        ST_BL3
    } back_state_t;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] az;
        logic signed [15:0] gy;
        logic [31:0]        elapsed;
        logic               restart;
    } tcf_item_t;

    typedef struct packed {
        logic [1:0]         gyro_range;
        logic signed [23:0] gyro_bias;
        logic [15:0]        blend_weight;
    } tcf_cfg_t;

    function automatic logic [23:0] atan_q24(input logic [4:0] i);
        logic [23:0] v;
        case (i)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            5'd24:   v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

    function automatic logic [19:0] gyro_scale_q24(input logic [1:0] r);
        logic [19:0] v;
        case (r)
            2'd0:    v = 20'd128060;
            2'd1:    v = 20'd256138;
            2'd2:    v = 20'd511487;
            default: v = 20'd1022991;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/tcf_front.sv
// Front end: accepts samples, measures elapsed time, flags restarts, queues work.
module tcf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  raw_accel_x,
    input  logic signed [15:0]  raw_accel_z,
    input  logic signed [15:0]  raw_gyro_y,
    input  logic [31:0]         tick_ms,
    input  logic [15:0]         gap_limit_ms,
    output logic                q_valid,
    output tcf_pkg::tcf_item_t  q_item,
    input  logic                q_pop
);
    import tcf_pkg::*;

    tcf_item_t   mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [31:0] last_tick_reg;
    logic [31:0] elapsed;
    logic        push;
    logic        pop;
    tcf_item_t   new_item;

    assign in_stall = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;
    assign elapsed  = tick_ms - last_tick_reg;

    always_comb
    begin
        new_item.ax      = raw_accel_x;
        new_item.az      = raw_accel_z;
        new_item.gy      = raw_gyro_y;
        new_item.elapsed = elapsed;
        new_item.restart = (elapsed > {16'd0, gap_limit_ms});
        wr_ptr_next      = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next      = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next       = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= 2'd0;
            last_tick_reg <= 32'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (push)
            begin
                last_tick_reg <= tick_ms;
            end
        end
    end

endmodule

FILE: hw/rtl/tcf_back.sv
// Back end: CORDIC tilt, gyro integration, divide by 1000, blend and saturate.
module tcf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  tcf_pkg::tcf_item_t  q_item,
    output logic                q_pop,
    input  tcf_pkg::tcf_cfg_t   cfg,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [27:0]  tilt_angle,
    output logic                restarted
);
    import tcf_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;

    logic signed [15:0] gy_reg;
    logic [15:0]        elapsed_reg;
    logic               restart_reg;

    logic signed [26:0] x_reg;
    logic signed [26:0] y_reg;
    logic signed [28:0] z_reg;
    logic [ITER_W-1:0]  cnt_reg;
    logic               zero_reg;

    logic signed [29:0] rate_reg;
    logic signed [33:0] radrate_reg;
    logic signed [50:0] plo_reg;
    logic               neg_reg;
    logic [47:0]        div_reg;
    logic [9:0]         rem_reg;
    logic [15:0]        qd_reg;
    logic [2:0]         dcnt_reg;
    logic signed [45:0] s_reg;
    logic signed [45:0] m1_reg;
    logic [39:0]        m2_reg;
    logic signed [27:0] angle_reg;
    logic               out_valid_reg;
    logic signed [27:0] tilt_reg;
    logic               restarted_reg;

    logic signed [26:0] x_init;
    logic signed [26:0] y_init;
    logic signed [28:0] z_init;
    logic signed [26:0] ax_s;
    logic signed [26:0] az_s;
    logic [4:0]         sh;
    logic signed [26:0] xs;
    logic signed [26:0] ys;
    logic signed [28:0] at;
    logic signed [28:0] acc;
    logic signed [36:0] p1;
    logic signed [29:0] rate_n;
    logic signed [57:0] p2;
    logic signed [50:0] plo_n;
    logic [47:0]        mag;
    logic [25:0]        num;
    logic [52:0]        rq;
    logic [15:0]        qd_n;
    logic [25:0]        qprod;
    logic signed [65:0] delta;
    logic signed [65:0] s_wide;
    logic signed [45:0] s_n;
    logic signed [45:0] m1_n;
    logic [16:0]        w;
    logic [39:0]        m2_n;
    logic signed [40:0] m3_n;
    logic signed [65:0] total;
    logic signed [65:0] res;
    logic signed [27:0] res_sat;
    logic               fire;

    assign out_valid  = out_valid_reg;
    assign tilt_angle = tilt_reg;
    assign restarted  = restarted_reg;
    assign fire       = (state_reg == ST_BL3) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_MUL4;
            ST_MUL4: state_next = ST_DIV;
            ST_DIV:
            begin
                if (dcnt_reg == 3'(DIV_STEPS - 1))
                begin
                    state_next = ST_BL1;
                end
            end
            ST_BL1:
            begin
                if (cnt_reg == ITER_W'(CORDIC_ITERATIONS))
                begin
                    state_next = ST_BL2;
                end
            end
            ST_BL2:  state_next = ST_BL3;
            ST_BL3:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // CORDIC setup, with a quarter turn into the right half plane when az is negative
    always_comb
    begin
        ax_s = 27'(q_item.ax) <<< 8;
        az_s = 27'(q_item.az) <<< 8;
        x_init = az_s;
        y_init = ax_s;
        z_init = '0;
        if (q_item.az < 0)
        begin
            if (q_item.ax >= 0)
            begin
                x_init = ax_s;
                y_init = -az_s;
                z_init = HALF_PI_Q24;
            end
            else
            begin
                x_init = -ax_s;
                y_init = az_s;
                z_init = -HALF_PI_Q24;
            end
        end
        sh  = 5'(cnt_reg);
        xs  = x_reg >>> sh;
        ys  = y_reg >>> sh;
        at  = $signed({5'd0, atan_q24(sh)});
        acc = zero_reg ? HALF_PI_Q24 : z_reg + HALF_PI_Q24;
    end

    always_comb
    begin
        p1     = 37'(gy_reg) * 37'($signed({1'b0, gyro_scale_q24(cfg.gyro_range)}));
        rate_n = 30'(p1 >>> 8) - 30'(cfg.gyro_bias);
        p2     = 58'(rate_reg) * 58'($signed({1'b0, DEG2RAD_Q32}));
        // elapsed fits 16 bits whenever the result integrates
        plo_n  = 51'(radrate_reg) * 51'($signed({1'b0, elapsed_reg}));
        mag    = (plo_reg < 0) ? 48'(-plo_reg) : 48'(plo_reg);
        num    = {rem_reg, div_reg[47:32]};
        rq     = 53'(num) * 53'(DIV_RECIP);
        qd_n   = 16'(rq >> DIV_SHIFT);
        qprod  = 26'(qd_reg) * 26'(MS_PER_S);
        delta  = neg_reg ? $signed({18'd0, div_reg}) : -$signed({18'd0, div_reg});
        s_wide = 66'(angle_reg) + delta;
        if (s_wide > 66'sd35184372088831)
        begin
            s_n = 46'sd35184372088831;
        end
        else if (s_wide < -66'sd35184372088832)
        begin
            s_n = -46'sd35184372088832;
        end
        else
        begin
            s_n = 46'(s_wide);
        end
        m1_n  = 46'($signed({1'b0, cfg.blend_weight})) * 46'(acc);
        w     = 17'd65536 - {1'b0, cfg.blend_weight};
        m2_n  = 40'(w) * 40'(s_reg[22:0]);
        m3_n  = 41'($signed({1'b0, w})) * 41'($signed(s_reg[45:23]));
        total = 66'(m1_reg) + $signed({26'd0, m2_reg}) + (66'(m3_n) <<< 23);
        res   = restart_reg ? 66'(acc) : (total >>> 16);
        if (res > 66'sd134217727)
        begin
            res_sat = 28'sd134217727;
        end
        else if (res < -66'sd134217728)
        begin
            res_sat = -28'sd134217728;
        end
        else
        begin
            res_sat = 28'(res);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            gy_reg      <= q_item.gy;
            elapsed_reg <= q_item.elapsed[15:0];
            restart_reg <= q_item.restart;
            x_reg       <= x_init;
            y_reg       <= y_init;
            z_reg       <= z_init;
            zero_reg    <= (q_item.ax == 16'sd0) && (q_item.az == 16'sd0);
        end
        else if (cnt_reg < ITER_W'(CORDIC_ITERATIONS))
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
        case (state_reg)
            ST_MUL1: rate_reg <= rate_n;
            ST_MUL2: radrate_reg <= 34'(p2 >>> 24);
            ST_MUL3: plo_reg <= plo_n;
            ST_MUL4:
            begin
                neg_reg <= (plo_reg < 0);
                div_reg <= mag;
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                if (!dcnt_reg[0])
                begin
                    qd_reg <= qd_n;
                end
                else
                begin
                    rem_reg <= 10'(num - qprod);
                    div_reg <= {div_reg[31:0], qd_reg};
                end
            end
            ST_BL1:
            begin
                s_reg  <= s_n;
                m1_reg <= m1_n;
            end
            ST_BL2:  m2_reg <= m2_n;
            default: ;
        endcase
        if (fire)
        begin
            tilt_reg      <= res_sat;
            restarted_reg <= restart_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= ITER_W'(CORDIC_ITERATIONS);
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            angle_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                cnt_reg <= '0;
            end
            else if (cnt_reg < ITER_W'(CORDIC_ITERATIONS))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == ST_DIV)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            else
            begin
                dcnt_reg <= '0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                angle_reg     <= res_sat;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/tilt_complementary_filter.sv
// Top level of the tilt complementary filter: configuration registers and the two halves.
// The back end takes one transaction at a time, paced by the 24-step CORDIC
// (one micro-rotation per cycle) plus the queue pop and the blend states BL1 to BL3.
// A two-entry queue decouples input from processing; output is held in a register.
// Reset: config returns to defaults, angle and last tick clear to zero, queue empties.
module tilt_complementary_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  raw_accel_x,
    input  logic signed [15:0]  raw_accel_z,
    input  logic signed [15:0]  raw_gyro_y,
    input  logic [31:0]         tick_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [27:0]  tilt_angle,
    output logic                restarted,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_wdata
);
    import tcf_pkg::*;

    tcf_cfg_t   cfg_reg;
    logic [15:0] gap_limit_reg;
    logic       q_valid;
    logic       q_pop;
    tcf_item_t  q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gyro_range   <= 2'd0;
            cfg_reg.gyro_bias    <= 24'sd0;
            cfg_reg.blend_weight <= 16'd197;
            gap_limit_reg        <= 16'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_GYRO_RANGE:   cfg_reg.gyro_range <= cfg_wdata[1:0];
                CFG_GYRO_BIAS:    cfg_reg.gyro_bias <= $signed(cfg_wdata);
                CFG_BLEND_WEIGHT: cfg_reg.blend_weight <= cfg_wdata[15:0];
                CFG_GAP_LIMIT:    gap_limit_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    tcf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_accel_x  (raw_accel_x),
        .raw_accel_z  (raw_accel_z),
        .raw_gyro_y   (raw_gyro_y),
        .tick_ms      (tick_ms),
        .gap_limit_ms (gap_limit_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    tcf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .cfg        (cfg_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tilt_angle (tilt_angle),
        .restarted  (restarted)
    );

endmodule

FILE: hw/rtl/tcf_checker.sv
// Port-level checks for the tilt complementary filter, bound to the top level.
module tcf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic signed [27:0]  tilt_angle,
    input logic                restarted
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tilt_angle) && $stable(restarted))
        else $error("output transaction changed while stalled");

    a_stall_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall rose without an accepted transaction");

    a_restart_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && restarted |-> tilt_angle > -28'sd27000000 && tilt_angle < 28'sd80000000)
        else $error("restart angle outside accelerometer tilt range");

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (.*);
